[hw/rtl/assert_macros.svh]
// assertion macros used by the transfer rate meter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hw/rtl/trm_pkg.sv]
// shared constants and types for the transfer rate meter
package trm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int BYTES_W   = 31;
    localparam int MS_W      = 31;
    localparam int CFG_W     = 10;
    localparam int MUL_W     = 10;
    localparam int NUM_W     = BYTES_W + MUL_W + FRAC_BITS;
    localparam int RATE_W    = 49;
    localparam int SCALED_W  = 19;
    localparam int UNIT_W    = 2;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    localparam logic [MUL_W-1:0]  BYTES_TO_MS   = MUL_W'(1000);
    localparam logic [CFG_W-1:0]  CFG_RESET     = CFG_W'(1);
    localparam logic [63:0]       RATE_MAX      = (64'd1 << RATE_W) - 64'd1;

    localparam logic [UNIT_W-1:0] UNIT_B  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_KB = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MB = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_GB = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/transfer_rate_meter.sv]
// transfer rate meter top level: sequencer, rise limit and unit scaling
// an accepted input transfer passes the load, divide, cap and output states before its result is registered
// items are taken one at a time, each passing through the 49-step restoring divider
// input stall stays high from acceptance until the result is loaded into the output register
// a finished result may wait in the output register while the next item is accepted
// synchronous active-low reset clears the sequencer, the output valid, the previous rate and sets the interval to 1
`include "assert_macros.svh"
module transfer_rate_meter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [trm_pkg::CFG_W-1:0]    i_zero_interval_ms,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [trm_pkg::BYTES_W-1:0]  i_byte_count,
    input  logic [trm_pkg::MS_W-1:0]     i_elapsed_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [trm_pkg::SCALED_W-1:0] o_scaled_rate,
    output logic [trm_pkg::UNIT_W-1:0]   o_unit_code
);
    import trm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CAP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          r_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [NUM_W-1:0]    r_num;
    logic [MS_W-1:0]     r_ms;
    logic [RATE_W-1:0]   r_rate;
    logic [RATE_W-1:0]   r_prev;
    logic                r_out_valid;
    logic [SCALED_W-1:0] r_scaled;
    logic [UNIT_W-1:0]   r_unit;

    logic                in_xfer;
    logic                out_free;
    logic [MS_W-1:0]     ms_sel;
    logic [NUM_W-1:0]    num_prod;
    logic [NUM_W-1:0]    quotient;
    t_div_stat           div_stat;
    logic                q_sat;
    logic [RATE_W:0]     cap;
    logic [RATE_W-1:0]   capped;
    logic [RATE_W-1:0]   shifted;
    logic [UNIT_W-1:0]   unit_sel;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // substitute interval, zero config acts as one
    always_comb begin
        if (i_elapsed_ms != '0) begin
            ms_sel = i_elapsed_ms;
        end else if (r_cfg != '0) begin
            ms_sel = MS_W'(r_cfg);
        end else begin
            ms_sel = MS_W'(1);
        end
    end

    assign num_prod = (NUM_W'(i_byte_count) * NUM_W'(BYTES_TO_MS)) << FRAC_BITS;

    trm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_num),
        .i_divisor  (r_ms),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    assign q_sat = 64'(quotient) > RATE_MAX;

    // rise limit
    always_comb begin
        cap    = {1'b0, r_prev} + {2'b00, r_prev[RATE_W-1:1]};
        capped = r_rate;
        if (r_prev != '0 && r_rate > r_prev && {1'b0, r_rate} > cap) begin
            capped = cap[RATE_W-1:0];
        end
    end

    // unit selection
    always_comb begin
        priority if ((r_rate >> (FRAC_BITS + 10)) == '0) begin
            unit_sel = UNIT_B;
            shifted  = r_rate;
        end else if ((r_rate >> (FRAC_BITS + 20)) == '0) begin
            unit_sel = UNIT_KB;
            shifted  = r_rate >> 10;
        end else if ((r_rate >> (FRAC_BITS + 30)) == '0) begin
            unit_sel = UNIT_MB;
            shifted  = r_rate >> 20;
        end else begin
            unit_sel = UNIT_GB;
            shifted  = r_rate >> 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_zero_interval_ms;
            end
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_prev  <= capped;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_num <= num_prod;
            r_ms  <= ms_sel;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_rate <= q_sat ? RATE_W'(RATE_MAX) : quotient[RATE_W-1:0];
        end
        if (r_state == S_CAP) begin
            r_rate <= capped;
        end
        if (r_state == S_OUT && out_free) begin
            r_scaled <= shifted[SCALED_W-1:0];
            r_unit   <= unit_sel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scaled_rate = r_scaled;
    assign o_unit_code   = r_unit;

    `ASSERT_PROP(a_div_runs, i_clk, i_rst_n, (r_state == S_LOAD) |=> div_stat.busy)
    `ASSERT_NEVER(a_done_in_div, i_clk, i_rst_n, div_stat.done && (r_state != S_DIV))
    `ASSERT_PROP(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
    `ASSERT_NEVER(a_busy_when_idle, i_clk, i_rst_n, div_stat.busy && (r_state == S_IDLE))

endmodule

[hw/rtl/trm_div.sv]
// restoring divider, one quotient bit per cycle
module trm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [trm_pkg::NUM_W-1:0] i_dividend,
    input  logic [trm_pkg::MS_W-1:0]  i_divisor,
    output logic [trm_pkg::NUM_W-1:0] o_quotient,
    output trm_pkg::t_div_stat        o_stat
);
    import trm_pkg::*;

    logic [NUM_W-1:0] r_quo;
    logic [MS_W-1:0]  r_rem;
    logic [MS_W-1:0]  r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [MS_W:0]    trial;
    logic [MS_W+1:0]  diff;
    logic             q_bit;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dvs};
    assign q_bit = ~diff[MS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[MS_W-1:0] : trial[MS_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[dv/transfer_rate_meter_test.sv]
// testbench for the transfer rate meter: predicted rates checked against every output transfer
`timescale 1ns / 100ps

module transfer_rate_meter_test;
    import trm_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [MS_W-1:0] MS_MAX = '1;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled;
        logic [UNIT_W-1:0]   unit_code;
    } t_rate_result;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [MS_W-1:0]    ms;
    } t_meter_item;

    class t_rate_tracker;
        logic [CFG_W-1:0] interval_ms;
        logic [63:0]      last_rate;
        t_rate_result     expected_rates[$];
        int               errors;

        function new();
            interval_ms = CFG_RESET;
            last_rate = '0;
            errors = 0;
        endfunction

        function void set_interval(logic [CFG_W-1:0] value);
            interval_ms = value;
        endfunction

        function int pending();
            return expected_rates.size();
        endfunction

        function void note_transfer(logic [BYTES_W-1:0] bytes, logic [MS_W-1:0] ms_in);
            logic [63:0] ms;
            logic [63:0] rate;
            logic [63:0] cap;
            logic [63:0] one;
            int shift;
            t_rate_result res;
            ms = (ms_in == '0) ? 64'(interval_ms) : 64'(ms_in);
            if (ms == '0)
                ms = 64'd1;
            rate = ((64'(bytes) * 64'd1000) << FRAC_BITS) / ms;
            if (rate > RATE_MAX)
                rate = RATE_MAX;
            if (last_rate != '0 && rate > last_rate) begin
                cap = last_rate + (last_rate >> 1);
                if (rate > cap)
                    rate = cap;
            end
            last_rate = rate;
            one = 64'd1 << FRAC_BITS;
            if (rate < (one << 10)) begin
                res.unit_code = UNIT_B;
                shift = 0;
            end else if (rate < (one << 20)) begin
                res.unit_code = UNIT_KB;
                shift = 10;
            end else if (rate < (one << 30)) begin
                res.unit_code = UNIT_MB;
                shift = 20;
            end else begin
                res.unit_code = UNIT_GB;
                shift = 30;
            end
            res.scaled = SCALED_W'(rate >> shift);
            expected_rates.push_back(res);
        endfunction

        function void check_result(logic [SCALED_W-1:0] scaled, logic [UNIT_W-1:0] unit_code);
            t_rate_result exp_res;
            if (expected_rates.size() == 0) begin
                $error("unexpected result: scaled_rate %0d unit_code %0d", scaled, unit_code);
                errors++;
                return;
            end
            exp_res = expected_rates.pop_front();
            if (scaled !== exp_res.scaled) begin
                $error("scaled_rate mismatch: expected %0d, actual %0d", exp_res.scaled, scaled);
                errors++;
            end
            if (unit_code !== exp_res.unit_code) begin
                $error("unit_code mismatch: expected %0d, actual %0d",
                       exp_res.unit_code, unit_code);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_zero_interval_ms = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [BYTES_W-1:0]  i_byte_count = '0;
    logic [MS_W-1:0]     i_elapsed_ms = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [SCALED_W-1:0] o_scaled_rate;
    logic [UNIT_W-1:0]   o_unit_code;

    t_rate_tracker meter = new();
    t_meter_item   item_queue[$];
    int unsigned   cycle_count = 0;

    transfer_rate_meter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_zero_interval_ms (i_zero_interval_ms),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_byte_count       (i_byte_count),
        .i_elapsed_ms       (i_elapsed_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_scaled_rate      (o_scaled_rate),
        .o_unit_code        (o_unit_code)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: free-running, heavy random, light random, then periodic long stalls
    always @(posedge i_clk) begin
        case (cycle_count[11:10])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 7) == 0);
            default: i_out_stall <= (cycle_count[5:3] == 3'd0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            meter.check_result(o_scaled_rate, o_unit_code);
    end

    function automatic void add_item(logic [BYTES_W-1:0] bytes, logic [MS_W-1:0] ms);
        t_meter_item it;
        it.bytes = bytes;
        it.ms = ms;
        item_queue.push_back(it);
    endfunction

    function automatic logic [30:0] random_magnitude();
        return 31'($urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1));
    endfunction

    function automatic void add_random_items(int count);
        logic [BYTES_W-1:0] bytes;
        logic [MS_W-1:0] ms;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 15))
                0: bytes = '0;
                1: bytes = BYTES_MAX;
                default: bytes = random_magnitude();
            endcase
            case ($urandom_range(0, 7))
                0: ms = '0;
                1: ms = MS_MAX;
                default: ms = random_magnitude();
            endcase
            add_item(bytes, ms);
        end
    endfunction

    task automatic send_items(input int max_burst);
        t_meter_item it;
        int burst_left;
        burst_left = $urandom_range(1, max_burst);
        while (item_queue.size() > 0) begin
            it = item_queue.pop_front();
            i_in_valid <= 1'b1;
            i_byte_count <= it.bytes;
            i_elapsed_ms <= it.ms;
            @(posedge i_clk);
            while (o_in_stall)
                @(posedge i_clk);
            meter.note_transfer(it.bytes, it.ms);
            burst_left--;
            if (item_queue.size() == 0 || burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, max_burst);
            end
        end
    endtask

    task automatic drain();
        while (meter.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_zero_interval_ms <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        meter.set_interval(value);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] intervals[5];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset interval, extremes, unit boundaries, rise limit
        add_item('0, '0);
        add_item(BYTES_MAX, 31'd1);
        add_item(BYTES_MAX, MS_MAX);
        add_item(31'd1, MS_MAX);
        add_item(31'd1023, 31'd1000);
        add_item(31'd1024, 31'd1000);
        add_item('0, 31'd5);
        add_item(31'd1048575, 31'd1000);
        add_item(31'd1048576, 31'd1000);
        add_item('0, 31'd1);
        add_item(31'd1073741823, 31'd1000);
        add_item(31'd1073741824, 31'd1000);
        add_item('0, 31'd1);
        add_item(31'd1000, 31'd1000);
        add_item(31'd3000, 31'd1000);
        add_item(31'd3000, 31'd1000);
        add_item(31'd100, 31'd1000);
        add_item('0, MS_MAX);
        add_item(31'h55555555, 31'h2aaaaaaa);
        add_item(31'h2aaaaaaa, 31'h55555555);
        send_items(4);

        // zero substitute interval acts as one
        write_interval('0);
        add_item(31'd1000, '0);
        add_item(BYTES_MAX, '0);
        add_item('0, '0);
        send_items(2);

        intervals[0] = CFG_W'(1000);
        intervals[1] = '1;
        intervals[2] = CFG_RESET;
        intervals[3] = CFG_W'($urandom_range(2, 999));
        intervals[4] = CFG_W'($urandom_range(0, 1023));
        for (int p = 0; p < 5; p++) begin
            write_interval(intervals[p]);
            add_random_items(226);
            send_items((p % 2 == 0) ? 8 : 400);
        end

        drain();
        if (meter.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/trm_pkg.sv
hw/rtl/trm_div.sv
hw/rtl/transfer_rate_meter.sv
dv/transfer_rate_meter_test.sv
